FILE: hw/rtl/pstf_pkg.sv
// Package with status codes, format codes and shared types for the PCM converter.
`default_nettype none
package pstf_pkg;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NONFINITE   = 2'd1,
      ST_RANGE       = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   localparam logic [1:0] CSR_FILE_KIND = 2'd0;
   localparam logic [1:0] CSR_ENCODING  = 2'd1;
   localparam logic [1:0] CSR_BITS      = 2'd2;

   localparam logic [6:0] BITS_RESET = 7'd16;

   // Format settings as seen by the conversion logic.
   typedef struct packed {
      logic       aiff;
      logic       is_float;
      logic [6:0] bits;
   } fmt_type;

   // Result word: value and status.
   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/pstf_convert.sv
// Combinational conversion of one raw sample word to a float32 pattern and status.
`default_nettype none
module pstf_convert (
   input  wire pstf_pkg::fmt_type    fmt,
   input  wire logic [63:0]          raw,
   output pstf_pkg::result_type      res
);
   import pstf_pkg::*;

   logic [31:0] le32, be32, u;
   logic [31:0] sval;
   logic        neg;
   logic [31:0] mag;
   logic [4:0]  lz;
   logic        found;
   logic [31:0] norm;
   logic [7:0]  exp_i;
   logic [23:0] mant_i;
   logic        rnd_i;
   logic [24:0] mant_r;
   logic [31:0] int_val;
   logic [7:0]  wexp;

   logic        d_sign;
   logic [10:0] d_exp;
   logic [51:0] d_frac;
   logic [31:0] dbl_val;
   logic        dbl_range;
   logic [52:0] sig;
   logic [11:0] sh;
   logic [55:0] shifted;
   logic        sticky;
   logic [23:0] keep;
   logic        g, rs;
   logic [24:0] kr;
   logic [12:0] e_adj;
   logic [30:0] mag_f;

   // Byte assembly in both byte orders.
   always_comb begin
      le32 = raw[31:0];
      unique case (fmt.bits)
         7'd8:    be32 = {24'd0, raw[7:0]};
         7'd16:   be32 = {16'd0, raw[7:0], raw[15:8]};
         7'd24:   be32 = {8'd0, raw[7:0], raw[15:8], raw[23:16]};
         default: be32 = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      endcase
      u = fmt.aiff ? be32 : le32;
   end

   // Sign extend to 32 bits; WAV 8-bit is offset binary.
   always_comb begin
      unique case (fmt.bits)
         7'd8:    sval = fmt.aiff ? {{24{u[7]}}, u[7:0]} : {{24{~u[7]}}, ~u[7], u[6:0]};
         7'd16:   sval = {{16{u[15]}}, u[15:0]};
         7'd24:   sval = {{8{u[23]}}, u[23:0]};
         default: sval = u;
      endcase
      neg = sval[31];
      mag = neg ? (~sval + 32'd1) : sval;
   end

   // Leading zero count of the magnitude.
   always_comb begin
      lz = 5'd0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && mag[i]) begin
            lz = 5'(31 - i);
            found = 1'b1;
         end
      end
      norm = mag << lz;
   end

   // Integer path: exponent from width and leading zeros, round to nearest even.
   always_comb begin
      unique case (fmt.bits)
         7'd8:    wexp = 8'd127 - 8'd7;
         7'd16:   wexp = 8'd127 - 8'd15;
         7'd24:   wexp = 8'd127 - 8'd23;
         default: wexp = 8'd127 - 8'd31;
      endcase
      mant_i = norm[31:8];
      rnd_i  = norm[7] & (norm[8] | (|norm[6:0]));
      mant_r = {1'b0, mant_i} + {24'd0, rnd_i};
      exp_i  = wexp + 8'd31 - {3'd0, lz} + {7'd0, mant_r[24]};
      if (!found)
         int_val = 32'd0;
      else
         int_val = {neg, exp_i, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
   end

   // Double path: narrow to float32 with nearest even rounding and subnormals.
   always_comb begin
      d_sign = raw[63];
      d_exp  = raw[62:52];
      d_frac = raw[51:0];
      sig    = {(d_exp != 11'd0), d_frac};
      // Target biased exponent of float: d_exp - 896; below 1 means subnormal.
      if (d_exp > 11'd896)
         sh = 12'd29;
      else
         sh = 12'd29 + 12'd897 - {1'b0, d_exp};
      if (sh > 12'd55) begin
         shifted = 56'd0;
         sticky  = |sig;
      end else begin
         shifted = {sig, 3'b000} >> sh[5:0];
         sticky  = |({sig, 3'b000} & ~(56'hFFFFFFFFFFFFFF << sh[5:0]));
      end
      keep = shifted[26:3];
      g    = shifted[2];
      rs   = (|shifted[1:0]) | sticky;
      kr   = {1'b0, keep} + {24'd0, g & (rs | keep[0])};
      e_adj = (d_exp > 11'd896) ? ({2'b00, d_exp} - 13'd896) : 13'd0;
      // Mantissa carry into the exponent field is handled by plain addition.
      mag_f = {e_adj[7:0] - {7'd0, (d_exp > 11'd896)}, 23'd0} + {6'd0, kr};
      // Anything strictly above the largest float is out of range.
      dbl_range = (e_adj > 13'd254) || (e_adj == 13'd254 && (&keep) && (g || rs));
      dbl_val = {d_sign, mag_f};
   end

   // Select result and status.
   always_comb begin
      res.value  = 32'd0;
      res.status = ST_OK;
      if (fmt.is_float) begin
         if (fmt.aiff)
            res.status = ST_UNSUPPORTED;
         else if (fmt.bits == 7'd32) begin
            if (le32[30:23] == 8'hFF) res.status = ST_NONFINITE;
            else res.value = le32;
         end else if (fmt.bits == 7'd64) begin
            if (d_exp == 11'h7FF) res.status = ST_NONFINITE;
            else if (dbl_range) res.status = ST_RANGE;
            else res.value = dbl_val;
         end else
            res.status = ST_UNSUPPORTED;
      end else if (fmt.bits == 7'd8 || fmt.bits == 7'd16 ||
                   fmt.bits == 7'd24 || fmt.bits == 7'd32) begin
         res.value = int_val;
      end else
         res.status = ST_UNSUPPORTED;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/pcm_sample_to_float_core.sv
// An accepted req word reaches its rsp word through two registers: the input register, then the result register.
// Throughput: one word per cycle while rsp_tready is not held low; the conversion is one pass of combinational logic.
// A full result register with a stalled consumer holds req_tready low only while the input
// register is also full. Reset is synchronous and active high: it empties both registers and
// sets file_kind to WAV, sample_encoding to integer and sample_bits to 16.
`default_nettype none
module pcm_sample_to_float_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // sample_bytes[63:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // sample_value[31:0], status[33:32], zeros[39:34]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata
);
   import pstf_pkg::*;

   fmt_type     fmt_ff, fmt_in;
   logic        in_valid_ff, in_valid_in;
   logic [63:0] in_data_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  conv;
   logic        advance;

   // Configuration registers.
   always_comb begin
      fmt_in = fmt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FILE_KIND: fmt_in.aiff     = csr_wdata[0];
            CSR_ENCODING:  fmt_in.is_float = csr_wdata[0];
            CSR_BITS:      fmt_in.bits     = csr_wdata;
            default:       fmt_in = fmt_ff;
         endcase
      end
   end

   pstf_convert u_convert (
      .fmt (fmt_ff),
      .raw (in_data_ff),
      .res (conv)
   );

   // Two-stage pipeline control: stage moves when the result register is free.
   always_comb begin
      advance      = !out_valid_ff || rsp_tready;
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= '{aiff: 1'b0, is_float: 1'b0, bits: BITS_RESET};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_data_ff <= req_tdata;
      if (advance && in_valid_ff) out_ff <= conv;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.status, out_ff.value};

endmodule
`default_nettype wire

FILE: hw/rtl/pstf_checker.sv
// Port-level checker for the PCM converter, bound to the top level.
`default_nettype none
module pstf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import pstf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("rsp padding not zero");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("error word carries a value");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(reset) |-> req_tready)
      else $error("input stalled with empty output");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");
endmodule

bind pcm_sample_to_float_core pstf_checker u_pstf_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
